// ----- rtl/core/dvb_transport_descriptor_parser_assert.svh -----
// ---------------------------------------------------------------------------
// dvb transport descriptor parser assertion macros
// shared forms for the concurrent checks of the parser
// ---------------------------------------------------------------------------
`ifndef DVB_TRANSPORT_DESCRIPTOR_PARSER_ASSERT_SVH
`define DVB_TRANSPORT_DESCRIPTOR_PARSER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define DTDP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtdp check failed");

// next-cycle implication, disabled while reset is low
`define DTDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtdp check failed");

`endif

// ----- rtl/core/dtdp_pkg.sv -----
// ---------------------------------------------------------------------------
// dtdp_pkg
// types, codes and helpers of the dvb transport descriptor parser
// ---------------------------------------------------------------------------
package dtdp_pkg;

    // input transaction payload
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        loop_start;
        logic [11:0] loop_length;
    } t_in_item;

    // result transaction payload
    typedef struct packed {
        logic [2:0]  record_kind;
        logic [15:0] value_a;
        logic [15:0] value_b;
        logic [11:0] descriptor_loop_length;
        logic [31:0] frequency_bcd;
        logic [15:0] orbital_bcd;
        logic [7:0]  modulation_flags;
        logic [27:0] symbol_rate_bcd;
        logic [3:0]  fec_code;
    } t_out_item;

    // record kinds
    localparam logic [2:0] KIND_TS_HDR   = 3'd0;
    localparam logic [2:0] KIND_DESC_HDR = 3'd1;
    localparam logic [2:0] KIND_NAME     = 3'd2;
    localparam logic [2:0] KIND_SERVICE  = 3'd3;
    localparam logic [2:0] KIND_SAT      = 3'd4;
    localparam logic [2:0] KIND_ERR      = 3'd5;

    // error codes
    localparam logic [15:0] ERR_SAT_LEN  = 16'd0;
    localparam logic [15:0] ERR_TS_OVF   = 16'd1;
    localparam logic [15:0] ERR_DESC_OVF = 16'd2;

    // descriptor tags
    localparam logic [7:0] TAG_NAME    = 8'h40;
    localparam logic [7:0] TAG_SERVICE = 8'h41;
    localparam logic [7:0] TAG_SAT     = 8'h43;

    // layout constants
    localparam logic [7:0] SAT_DESC_LEN  = 8'd11;
    localparam logic [7:0] LEN_HI_MASK   = 8'h0F;
    localparam int         HDR_BYTES     = 5;
    localparam int         SVC_BYTES     = 2;
    localparam int         SAT_BYTES     = 10;

    // result queue
    localparam int FIFO_AW    = 2;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    // all-zero record
    localparam t_out_item REC_ZERO = '0;

    // error record with the given code
    function automatic t_out_item mk_err(input logic [15:0] code);
        t_out_item r;
        r             = REC_ZERO;
        r.record_kind = KIND_ERR;
        r.value_a     = code;
        return r;
    endfunction

endpackage

// ----- rtl/core/dtdp_in_if.sv -----
// ---------------------------------------------------------------------------
// dtdp_in_if
// valid/ready channel carrying one loop byte per transaction
// ---------------------------------------------------------------------------
interface dtdp_in_if;
    logic               valid;
    logic               ready;
    dtdp_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/dtdp_out_if.sv -----
// ---------------------------------------------------------------------------
// dtdp_out_if
// valid/ready channel carrying one parsed record per transaction
// ---------------------------------------------------------------------------
interface dtdp_out_if;
    logic                valid;
    logic                ready;
    dtdp_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/dvb_transport_descriptor_parser.sv -----
// ---------------------------------------------------------------------------
// dvb_transport_descriptor_parser
// walks the transport stream loop of a network information table, one byte
// per transaction, and emits header, name, service, satellite and error records
// ---------------------------------------------------------------------------
//  channel   direction  payload
//  i_in      sink       data_byte, loop_start, loop_length
//  o_out     source     record_kind, value_a/b, descriptor_loop_length,
//                       frequency/orbital/flags/symbol rate/fec fields
//
//  one byte is taken per cycle; its records are formed in the same cycle
//  and written into a four-entry result queue, read out one per cycle
//  while o_out.ready is high; a byte gives zero, one or two records;
//  i_in.ready is high while the queue has room for two, so the byte rate
//  is one per cycle whenever records drain at least as fast as made
//  synchronous active-low reset stops the parser and empties the queue
// ---------------------------------------------------------------------------
`include "dvb_transport_descriptor_parser_assert.svh"

module dvb_transport_descriptor_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    dtdp_in_if.sink          i_in,
    dtdp_out_if.source       o_out
);

    // parse phases
    typedef enum logic [5:0] {
        ST_STOP = 6'b000001,
        ST_HEAD = 6'b000010,
        ST_TAG  = 6'b000100,
        ST_LEN  = 6'b001000,
        ST_BODY = 6'b010000,
        ST_SKIP = 6'b100000
    } t_phase;

    // parser state
    t_phase      r_phase, n_phase;
    logic [7:0]  r_hdr [dtdp_pkg::HDR_BYTES];
    logic [7:0]  n_hdr [dtdp_pkg::HDR_BYTES];
    logic [2:0]  r_hdr_idx, n_hdr_idx;
    logic [11:0] r_loop_total, n_loop_total;
    logic [11:0] r_loop_consumed, n_loop_consumed;
    logic [11:0] r_ts_rem, n_ts_rem;
    logic [11:0] r_ts_len, n_ts_len;
    logic [7:0]  r_tag, n_tag;
    logic [7:0]  r_desc_rem, n_desc_rem;
    logic [7:0]  r_svc [dtdp_pkg::SVC_BYTES];
    logic [7:0]  n_svc [dtdp_pkg::SVC_BYTES];
    logic [1:0]  r_svc_idx, n_svc_idx;
    logic [7:0]  r_sat [dtdp_pkg::SAT_BYTES];
    logic [7:0]  n_sat [dtdp_pkg::SAT_BYTES];

    // result queue
    dtdp_pkg::t_out_item              r_fifo [dtdp_pkg::FIFO_DEPTH];
    logic [dtdp_pkg::FIFO_AW-1:0]     r_wr_ptr, r_rd_ptr, w_wr_ptr_nx;
    logic [dtdp_pkg::FIFO_AW:0]       r_count;

    // per-byte results
    logic                w_acc, w_pop;
    logic                w_prim_v, w_sec_err, w_ovf, w_in_region;
    dtdp_pkg::t_out_item w_prim;
    logic                w_v0, w_v1;
    dtdp_pkg::t_out_item w_rec0, w_rec1;
    logic [1:0]          w_push;
    logic [11:0]         w_tl, w_left;
    logic [7:0]          w_byte;

    assign w_byte = i_in.data.data_byte;
    assign w_acc  = i_in.valid & i_in.ready;
    assign w_pop  = o_out.valid & o_out.ready;

    // handshake: take a byte while two queue slots are free
    assign i_in.ready  = (r_count <= (dtdp_pkg::FIFO_AW + 1)'(dtdp_pkg::FIFO_DEPTH - 2));
    assign o_out.valid = (r_count != '0);
    assign o_out.data  = r_fifo[r_rd_ptr];

    // high nibble of the transport length, from the last header byte
    function automatic logic [3:0] w_byte_hi_nibble(input logic [7:0] b);
        logic [7:0] m;
        m = b & dtdp_pkg::LEN_HI_MASK;
        return m[3:0];
    endfunction

    // byte parse: next state and records
    always_comb begin
        n_phase         = r_phase;
        n_hdr           = r_hdr;
        n_hdr_idx       = r_hdr_idx;
        n_loop_total    = r_loop_total;
        n_loop_consumed = r_loop_consumed;
        n_ts_rem        = r_ts_rem;
        n_ts_len        = r_ts_len;
        n_tag           = r_tag;
        n_desc_rem      = r_desc_rem;
        n_svc           = r_svc;
        n_svc_idx       = r_svc_idx;
        n_sat           = r_sat;
        w_prim_v        = 1'b0;
        w_prim          = dtdp_pkg::REC_ZERO;
        w_sec_err       = 1'b0;
        w_ovf           = 1'b0;
        w_in_region     = 1'b0;
        w_tl            = {w_byte_hi_nibble(r_hdr[dtdp_pkg::HDR_BYTES-1]), w_byte};
        w_left          = '0;

        if (w_acc) begin
            // new loop restarts the walk
            if (i_in.data.loop_start) begin
                n_loop_total    = i_in.data.loop_length;
                n_loop_consumed = '0;
                n_hdr_idx       = '0;
                n_phase         = (i_in.data.loop_length != '0) ? ST_HEAD : ST_STOP;
            end

            if (n_phase != ST_STOP && n_loop_consumed < n_loop_total) begin
                w_in_region = (n_phase == ST_TAG) || (n_phase == ST_LEN) ||
                              (n_phase == ST_BODY) || (n_phase == ST_SKIP);
                w_left      = n_loop_total - (n_loop_consumed + 12'd1);

                unique case (n_phase)
                    // transport header: five bytes, then the length low byte
                    ST_HEAD: begin
                        if (n_hdr_idx < 3'(dtdp_pkg::HDR_BYTES)) begin
                            for (int i = 0; i < dtdp_pkg::HDR_BYTES - 1; i++) begin
                                n_hdr[i] = r_hdr[i+1];
                            end
                            n_hdr[dtdp_pkg::HDR_BYTES-1] = w_byte;
                            n_hdr_idx = n_hdr_idx + 3'd1;
                        end else begin
                            n_hdr_idx = '0;
                            if (w_tl > n_loop_total) begin
                                w_prim_v = 1'b1;
                                w_prim   = dtdp_pkg::mk_err(dtdp_pkg::ERR_TS_OVF);
                                n_phase  = ST_STOP;
                                w_ovf    = 1'b1;
                            end else if (w_tl != '0) begin
                                w_prim_v                      = 1'b1;
                                w_prim.record_kind            = dtdp_pkg::KIND_TS_HDR;
                                w_prim.value_a                = {r_hdr[0], r_hdr[1]};
                                w_prim.value_b                = {r_hdr[2], r_hdr[3]};
                                w_prim.descriptor_loop_length = w_tl;
                                n_ts_len = (w_tl < w_left) ? w_tl : w_left;
                                n_ts_rem = n_ts_len;
                                if (n_ts_len != '0) begin
                                    n_phase = ST_TAG;
                                end
                            end
                        end
                    end
                    ST_TAG: begin
                        n_tag   = w_byte;
                        n_phase = ST_LEN;
                    end
                    // descriptor length checks
                    ST_LEN: begin
                        if ({4'd0, w_byte} > n_ts_len) begin
                            w_prim_v = 1'b1;
                            w_prim   = dtdp_pkg::mk_err(dtdp_pkg::ERR_DESC_OVF);
                            n_phase  = ST_SKIP;
                        end else if (w_byte == '0) begin
                            n_phase = ST_TAG;
                        end else begin
                            w_prim_v           = 1'b1;
                            w_prim.record_kind = dtdp_pkg::KIND_DESC_HDR;
                            w_prim.value_a     = {8'd0, n_tag};
                            w_prim.value_b     = {8'd0, w_byte};
                            n_desc_rem         = w_byte;
                            n_svc_idx          = '0;
                            if (n_tag == dtdp_pkg::TAG_SAT &&
                                w_byte != dtdp_pkg::SAT_DESC_LEN) begin
                                w_sec_err = 1'b1;
                                n_tag     = '0;
                            end
                            n_phase = ST_BODY;
                        end
                    end
                    // descriptor body by tag
                    ST_BODY: begin
                        if (n_tag == dtdp_pkg::TAG_NAME) begin
                            w_prim_v           = 1'b1;
                            w_prim.record_kind = dtdp_pkg::KIND_NAME;
                            w_prim.value_a     = {8'd0, w_byte};
                        end else if (n_tag == dtdp_pkg::TAG_SERVICE) begin
                            if (n_svc_idx < 2'(dtdp_pkg::SVC_BYTES)) begin
                                n_svc[0]  = r_svc[1];
                                n_svc[1]  = w_byte;
                                n_svc_idx = n_svc_idx + 2'd1;
                            end else begin
                                w_prim_v           = 1'b1;
                                w_prim.record_kind = dtdp_pkg::KIND_SERVICE;
                                w_prim.value_a     = {r_svc[0], r_svc[1]};
                                w_prim.value_b     = {8'd0, w_byte};
                                n_svc_idx          = '0;
                            end
                        end else if (n_tag == dtdp_pkg::TAG_SAT) begin
                            if (n_desc_rem > 8'd1) begin
                                for (int i = 0; i < dtdp_pkg::SAT_BYTES - 1; i++) begin
                                    n_sat[i] = r_sat[i+1];
                                end
                                n_sat[dtdp_pkg::SAT_BYTES-1] = w_byte;
                            end else begin
                                w_prim_v                = 1'b1;
                                w_prim.record_kind      = dtdp_pkg::KIND_SAT;
                                w_prim.frequency_bcd    = {r_sat[0], r_sat[1],
                                                           r_sat[2], r_sat[3]};
                                w_prim.orbital_bcd      = {r_sat[4], r_sat[5]};
                                w_prim.modulation_flags = r_sat[6];
                                w_prim.symbol_rate_bcd  = {r_sat[7], r_sat[8],
                                                           r_sat[9], w_byte[7:4]};
                                w_prim.fec_code         = w_byte[3:0];
                            end
                        end
                        n_desc_rem = n_desc_rem - 8'd1;
                        if (n_desc_rem == '0) begin
                            n_phase = ST_TAG;
                        end
                    end
                    ST_SKIP: begin
                        n_phase = ST_SKIP;
                    end
                    default: begin
                        n_phase = ST_STOP;
                    end
                endcase

                if (!w_ovf) begin
                    // end of the descriptor loop
                    if (w_in_region) begin
                        n_ts_rem = n_ts_rem - 12'd1;
                        if (n_ts_rem == '0) begin
                            if (n_phase == ST_BODY && n_tag == dtdp_pkg::TAG_SAT &&
                                n_desc_rem != '0) begin
                                w_sec_err = 1'b1;
                            end
                            n_phase   = ST_HEAD;
                            n_hdr_idx = '0;
                        end
                    end
                    // end of the whole loop
                    n_loop_consumed = n_loop_consumed + 12'd1;
                    if (n_loop_consumed >= n_loop_total) begin
                        if (n_phase == ST_BODY && n_tag == dtdp_pkg::TAG_SAT &&
                            n_desc_rem != '0) begin
                            w_sec_err = 1'b1;
                        end
                        n_phase = ST_STOP;
                    end
                end
            end
        end
    end

    // order the records: main record first, satellite length error after
    always_comb begin
        w_v0   = w_prim_v | w_sec_err;
        w_v1   = w_prim_v & w_sec_err;
        w_rec0 = w_prim_v ? w_prim : dtdp_pkg::mk_err(dtdp_pkg::ERR_SAT_LEN);
        w_rec1 = dtdp_pkg::mk_err(dtdp_pkg::ERR_SAT_LEN);
        w_push = 2'(w_v0) + 2'(w_v1);
    end

    assign w_wr_ptr_nx = r_wr_ptr + dtdp_pkg::FIFO_AW'(1);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= ST_STOP;
            r_hdr_idx       <= '0;
            r_loop_total    <= '0;
            r_loop_consumed <= '0;
            r_ts_rem        <= '0;
            r_ts_len        <= '0;
            r_tag           <= '0;
            r_desc_rem      <= '0;
            r_svc_idx       <= '0;
            r_wr_ptr        <= '0;
            r_rd_ptr        <= '0;
            r_count         <= '0;
        end else begin
            r_phase         <= n_phase;
            r_hdr_idx       <= n_hdr_idx;
            r_loop_total    <= n_loop_total;
            r_loop_consumed <= n_loop_consumed;
            r_ts_rem        <= n_ts_rem;
            r_ts_len        <= n_ts_len;
            r_tag           <= n_tag;
            r_desc_rem      <= n_desc_rem;
            r_svc_idx       <= n_svc_idx;
            r_wr_ptr        <= r_wr_ptr + dtdp_pkg::FIFO_AW'(w_push);
            r_rd_ptr        <= r_rd_ptr + dtdp_pkg::FIFO_AW'(w_pop);
            r_count         <= r_count + (dtdp_pkg::FIFO_AW + 1)'(w_push)
                                       - (dtdp_pkg::FIFO_AW + 1)'(w_pop);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
        r_svc <= n_svc;
        r_sat <= n_sat;
        if (w_v0) begin
            r_fifo[r_wr_ptr] <= w_rec0;
        end
        if (w_v1) begin
            r_fifo[w_wr_ptr_nx] <= w_rec1;
        end
    end

    // checks
    `DTDP_ASSERT_NEXT(a_loop_end_stops, i_clk, i_rst_n,
        w_acc && !i_in.data.loop_start && r_phase != ST_STOP &&
            (r_loop_consumed + 12'd1 == r_loop_total),
        r_phase == ST_STOP)
    `DTDP_ASSERT_SAME(a_second_is_sat_err, i_clk, i_rst_n,
        w_v1,
        w_rec1.record_kind == dtdp_pkg::KIND_ERR && w_rec1.value_a == dtdp_pkg::ERR_SAT_LEN)
    `DTDP_ASSERT_NEXT(a_queue_growth, i_clk, i_rst_n,
        1'b1,
        r_count <= $past(r_count) + (dtdp_pkg::FIFO_AW + 1)'(2))

endmodule
